// ----- hdl/triangle_unit_normal_defines.svh -----
// ----------------------------------------------------------------------------
// triangle_unit_normal_defines
// Assertion macros for the triangle unit normal block.
// Bodies vanish under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset masking
`define TUN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that also holds during reset
`define TUN_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TUN_ASSERT(lbl, prop, msg)
`define TUN_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// ----- hdl/tun_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types of the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

	// pipeline control handed to the root pipeline
	typedef struct packed {
		logic en;     // all stages advance (the first stage only when valid is set)
		logic valid;  // item present at the root pipeline input
	} pipe_ctrl_t;

endpackage

// ----- hdl/tun_vtx_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_vtx_if
// Triangle item channel: three vertices, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tun_vtx_if #(
	parameter int CW = 16
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] first_x;
	logic signed [CW-1:0] first_y;
	logic signed [CW-1:0] first_z;
	logic signed [CW-1:0] second_x;
	logic signed [CW-1:0] second_y;
	logic signed [CW-1:0] second_z;
	logic signed [CW-1:0] third_x;
	logic signed [CW-1:0] third_y;
	logic signed [CW-1:0] third_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		       third_x, third_y, third_z,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
		       third_x, third_y, third_z,
		output ready
	);
endinterface

// ----- hdl/tun_nrm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_nrm_if
// Unit normal item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tun_nrm_if #(
	parameter int FB = 14
) ();
	logic                 valid;
	logic                 ready;
	logic signed [FB+1:0] normal_x;
	logic signed [FB+1:0] normal_y;
	logic signed [FB+1:0] normal_z;
	logic                 degenerate;

	modport source (
		output valid, normal_x, normal_y, normal_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, normal_x, normal_y, normal_z, degenerate,
		output ready
	);
endinterface

// ----- hdl/tun_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_root
// Pipelined bit-per-stage search of r = floor(sqrt(t / s)), NW result bits.
// ----------------------------------------------------------------------------
module tun_root #(
	parameter int SW = 72,
	parameter int TW = 100,
	parameter int NW = 16
) (
	input  logic               clk,
	input  tun_pkg::pipe_ctrl_t ctrl,
	input  logic [TW-1:0]      t,
	input  logic [SW-1:0]      s,
	output logic [NW-1:0]      r
);
	import tun_pkg::*;

	localparam int BW = SW + NW;          // r * s
	localparam int XW = SW + 2 * NW + 1;  // trial subtract headroom

	logic [NW-1:0][TW-1:0] rem_s, cur_rem, nxt_rem;  // t - r^2 s
	logic [NW-1:0][BW-1:0] acc_s, cur_acc, nxt_acc;  // r * s
	logic [NW-1:0][NW-1:0] root_s, cur_root, nxt_root;
	logic [NW-1:0][SW-1:0] sv_s, cur_s;

	always_comb begin
		cur_rem[0]  = t;
		cur_acc[0]  = '0;
		cur_root[0] = '0;
		cur_s[0]    = s;
		for (int i = 1; i < NW; i++) begin
			cur_rem[i]  = rem_s[i-1];
			cur_acc[i]  = acc_s[i-1];
			cur_root[i] = root_s[i-1];
			cur_s[i]    = sv_s[i-1];
		end
	end

	// stage i decides bit NW-1-i: (r+2^k)^2 s = r^2 s + 2^(k+1) r s + 2^2k s
	always_comb begin
		int k;
		logic [XW:0] x;
		logic [XW:0] y;
		logic [XW:0] trial;
		logic        ok;
		for (int i = 0; i < NW; i++) begin
			k = NW - 1 - i;
			x = (XW+1)'(cur_acc[i]) << (k + 1);
			y = (XW+1)'(cur_s[i]) << (2 * k);
			trial = (XW+1)'(cur_rem[i]) - x - y;
			ok = !trial[XW];
			nxt_rem[i]  = ok ? trial[TW-1:0] : cur_rem[i];
			nxt_acc[i]  = ok ? cur_acc[i] + (BW'(cur_s[i]) << k) : cur_acc[i];
			nxt_root[i] = cur_root[i] | (NW'(ok) << k);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NW; i++) begin
			if (ctrl.en && (i != 0 || ctrl.valid)) begin
				rem_s[i]  <= nxt_rem[i];
				acc_s[i]  <= nxt_acc[i];
				root_s[i] <= nxt_root[i];
				sv_s[i]   <= cur_s[i];
			end
		end
	end

	assign r = root_s[NW-1];

endmodule

// ----- hdl/triangle_unit_normal.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; the edge/cross/square
// front end and one root stage per result bit are all registered, so nothing is shared.
// A stall at the output freezes every stage; vertices.ready drops with it.
// Reset (arst_n low, asynchronous) clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: cross product of the edges, divided by its
// length, rounded to nearest in signed Q1.F.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_defines.svh"

module triangle_unit_normal #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	tun_vtx_if.sink   vertices,
	tun_nrm_if.source normal
);
	import tun_pkg::*;

	localparam int DW  = COORD_WIDTH + 1;  // edge component
	localparam int PW  = 2 * DW;           // edge product
	localparam int CXW = PW + 1;           // cross component
	localparam int MW  = PW;               // cross magnitude
	localparam int QW  = 2 * MW;           // squared magnitude
	localparam int SW  = QW + 2;           // squared length
	localparam int TW  = SW + 2 * NORMAL_FRAC_BITS;   // 4 c^2 2^2F
	localparam int NW  = NORMAL_FRAC_BITS + 2;        // root bits
	localparam int OW  = NORMAL_FRAC_BITS + 2;        // output width
	localparam int L   = 5 + NW + 1;                  // stages total
	localparam logic signed [OW-1:0] NRM_ONE = OW'(2 ** NORMAL_FRAC_BITS);

	// Global advance: output register empty or being drained.
	logic         adv;
	logic [L-1:0] vld_s;

	assign adv            = !vld_s[L-1] || normal.ready;
	assign vertices.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[L-2:0], vertices.valid};
		end
	end

	// Stage 1: edge vectors a = v2 - v1, b = v3 - v1 (exact, one extra bit)
	logic signed [DW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= DW'(vertices.second_x) - DW'(vertices.first_x);
			ay_s1 <= DW'(vertices.second_y) - DW'(vertices.first_y);
			az_s1 <= DW'(vertices.second_z) - DW'(vertices.first_z);
			bx_s1 <= DW'(vertices.third_x) - DW'(vertices.first_x);
			by_s1 <= DW'(vertices.third_y) - DW'(vertices.first_y);
			bz_s1 <= DW'(vertices.third_z) - DW'(vertices.first_z);
		end
	end

	// Stage 2: edge products ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx
	logic signed [PW-1:0] p_aybz_s2, p_azby_s2, p_azbx_s2, p_axbz_s2, p_axby_s2, p_aybx_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_aybz_s2 <= ay_s1 * bz_s1;
			p_azby_s2 <= az_s1 * by_s1;
			p_azbx_s2 <= az_s1 * bx_s1;
			p_axbz_s2 <= ax_s1 * bz_s1;
			p_axby_s2 <= ax_s1 * by_s1;
			p_aybx_s2 <= ay_s1 * bx_s1;
		end
	end

	// Stage 3: cross product, split into sign and magnitude
	logic signed [CXW-1:0] cx, cy, cz;
	logic [2:0][MW-1:0]    mag_s3;
	logic [2:0]            neg_s3;

	assign cx = CXW'(p_aybz_s2) - CXW'(p_azby_s2);
	assign cy = CXW'(p_azbx_s2) - CXW'(p_axbz_s2);
	assign cz = CXW'(p_axby_s2) - CXW'(p_aybx_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3    <= {cz[CXW-1], cy[CXW-1], cx[CXW-1]};
			mag_s3[0] <= cx[CXW-1] ? MW'(-cx) : MW'(cx);
			mag_s3[1] <= cy[CXW-1] ? MW'(-cy) : MW'(cy);
			mag_s3[2] <= cz[CXW-1] ? MW'(-cz) : MW'(cz);
		end
	end

	// Stage 4: squares; a zero vector is spotted here from the magnitudes
	logic [2:0][QW-1:0] sq_s4;
	logic [2:0]         neg_s4;
	logic               deg_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= mag_s3[i] * mag_s3[i];
			end
			neg_s4 <= neg_s3;
			deg_s4 <= (mag_s3[0] == '0) && (mag_s3[1] == '0) && (mag_s3[2] == '0);
		end
	end

	// Stage 5: squared length s and per-component target t = 4 c^2 2^2F.
	// The component is round(|c| 2^F / sqrt(s)) = (floor(sqrt(t/s)) + 1) / 2.
	logic [SW-1:0]      len2_s5;
	logic [2:0][TW-1:0] tgt_s5;
	logic [2:0]         neg_s5;
	logic               deg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s5 <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			for (int i = 0; i < 3; i++) begin
				tgt_s5[i] <= TW'(sq_s4[i]) << (2 * NORMAL_FRAC_BITS + 2);
			end
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
		end
	end

	// Root pipelines, one per component, NW stages each
	pipe_ctrl_t         root_ctrl;
	logic [2:0][NW-1:0] root;

	assign root_ctrl.en    = adv;
	assign root_ctrl.valid = vld_s[4];

	for (genvar g = 0; g < 3; g++) begin : g_root
		tun_root #(
			.SW(SW),
			.TW(TW),
			.NW(NW)
		) u_root (
			.clk  (clk),
			.ctrl (root_ctrl),
			.t    (tgt_s5[g]),
			.s    (len2_s5),
			.r    (root[g])
		);
	end

	// sign and degenerate flag ride alongside the root stages
	logic [NW-1:0][2:0] negd_s;
	logic [NW-1:0]      degd_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			negd_s <= {negd_s[NW-2:0], neg_s5};
			degd_s <= {degd_s[NW-2:0], deg_s5};
		end
	end

	// Output stage: halve the root with rounding up, apply sign, zero a degenerate normal
	logic [2:0][NORMAL_FRAC_BITS:0] q;
	logic [2:0][OW-1:0]             res;
	logic [2:0][OW-1:0]             nrm_s;
	logic                           deg_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i]   = (NORMAL_FRAC_BITS+1)'(((NW+1)'(root[i]) + (NW+1)'(1)) >> 1);
			res[i] = negd_s[NW-1][i] ? -OW'(q[i]) : OW'(q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s <= degd_s[NW-1];
			for (int i = 0; i < 3; i++) begin
				nrm_s[i] <= degd_s[NW-1] ? '0 : res[i];
			end
		end
	end

	assign normal.valid      = vld_s[L-1];
	assign normal.normal_x   = nrm_s[0];
	assign normal.normal_y   = nrm_s[1];
	assign normal.normal_z   = nrm_s[2];
	assign normal.degenerate = deg_s;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`TUN_ASSERT(a_deg_zero, (normal.valid && normal.degenerate) |-> (normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0), "degenerate item carries a nonzero normal")
	`TUN_ASSERT_ALL(a_ready, vertices.ready == (!normal.valid || normal.ready), "input ready does not follow output drain")
	`TUN_ASSERT(a_freeze, (normal.valid && !normal.ready) |=> $stable(vld_s), "pipeline moved while output stalled")
	`TUN_ASSERT(a_range, normal.valid |-> (normal.normal_x <= NRM_ONE && normal.normal_x >= -NRM_ONE), "normal x beyond unit range")

endmodule
